// ----- hw/rtl/ccp_pkg.sv -----
// constant pool parser package: item and result types, tag layouts, codes
// used by ccp_front, ccp_back and class_constant_pool_parser
// no dependencies
package ccp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tag;
    logic [2:0]  status;
    logic [15:0] first_index;
    logic [15:0] second_index;
    logic [63:0] value_bits;
    logic [15:0] text_length;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    LAY_ONE_IDX = 3'd0,
    LAY_TWO_IDX = 3'd1,
    LAY_VAL4    = 3'd2,
    LAY_VAL8    = 3'd3,
    LAY_MH      = 3'd4,
    LAY_UTF8    = 3'd5,
    LAY_BAD     = 3'd6
  } layout_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
    layout_t    layout;
    logic       utf8_bad;
  } class_item_t;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EARLY_END = 3'd1;
  localparam logic [2:0] ST_EARLY_UTF = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX = 3'd3;
  localparam logic [2:0] ST_BAD_UTF8  = 3'd4;
  localparam logic [2:0] ST_BAD_TAG   = 3'd5;

  localparam logic [7:0] TAG_UTF8         = 8'd1;
  localparam logic [7:0] TAG_INTEGER      = 8'd3;
  localparam logic [7:0] TAG_FLOAT        = 8'd4;
  localparam logic [7:0] TAG_LONG         = 8'd5;
  localparam logic [7:0] TAG_DOUBLE       = 8'd6;
  localparam logic [7:0] TAG_CLASS        = 8'd7;
  localparam logic [7:0] TAG_STRING       = 8'd8;
  localparam logic [7:0] TAG_FIELDREF     = 8'd9;
  localparam logic [7:0] TAG_METHODREF    = 8'd10;
  localparam logic [7:0] TAG_IFACEREF     = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE     = 8'd12;
  localparam logic [7:0] TAG_METHODHANDLE = 8'd15;
  localparam logic [7:0] TAG_METHODTYPE   = 8'd16;
  localparam logic [7:0] TAG_INVOKEDYN    = 8'd18;
  localparam logic [7:0] TAG_NONE         = 8'hFF;
  localparam logic [7:0] UTF8_BAD_FLOOR   = 8'hF0;

endpackage

// ----- hw/rtl/ccp_queue.sv -----
// small register queue with occupancy count, push/full and pop/empty sides
// generic width and depth, no package dependency
module ccp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/ccp_front.sv -----
// front end: classifies each incoming byte by tag layout and utf8 validity
// uses ccp_pkg types and tag constants
module ccp_front (
  input  ccp_pkg::in_item_t    item,
  output ccp_pkg::class_item_t classified
);

  ccp_pkg::layout_t layout;

  always_comb begin
    case (item.byte_value)
      ccp_pkg::TAG_CLASS, ccp_pkg::TAG_STRING, ccp_pkg::TAG_METHODTYPE: begin
        layout = ccp_pkg::LAY_ONE_IDX;
      end
      ccp_pkg::TAG_FIELDREF, ccp_pkg::TAG_METHODREF, ccp_pkg::TAG_IFACEREF,
      ccp_pkg::TAG_NAMETYPE, ccp_pkg::TAG_INVOKEDYN: begin
        layout = ccp_pkg::LAY_TWO_IDX;
      end
      ccp_pkg::TAG_INTEGER, ccp_pkg::TAG_FLOAT: begin
        layout = ccp_pkg::LAY_VAL4;
      end
      ccp_pkg::TAG_LONG, ccp_pkg::TAG_DOUBLE: begin
        layout = ccp_pkg::LAY_VAL8;
      end
      ccp_pkg::TAG_METHODHANDLE: begin
        layout = ccp_pkg::LAY_MH;
      end
      ccp_pkg::TAG_UTF8: begin
        layout = ccp_pkg::LAY_UTF8;
      end
      default: begin
        layout = ccp_pkg::LAY_BAD;
      end
    endcase
  end

  always_comb begin
    classified.byte_value    = item.byte_value;
    classified.end_of_stream = item.end_of_stream;
    classified.layout        = layout;
    classified.utf8_bad      = (item.byte_value == 8'd0) ||
                               (item.byte_value >= ccp_pkg::UTF8_BAD_FLOOR);
  end

endmodule

// ----- hw/rtl/ccp_back.sv -----
// back end: entry parser state machine, field assembly and result building
// uses ccp_pkg types and codes; takes classified items, emits results
module ccp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          pool_count,
  input  logic                 item_empty,
  input  ccp_pkg::class_item_t item,
  output logic                 item_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output ccp_pkg::result_t     res
);

  typedef enum logic [6:0] {
    PH_TAG   = 7'b0000001,
    PH_IDX1  = 7'b0000010,
    PH_IDX2  = 7'b0000100,
    PH_VALUE = 7'b0001000,
    PH_ULEN  = 7'b0010000,
    PH_UDATA = 7'b0100000,
    PH_HALT  = 7'b1000000
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  current_tag;
  logic [7:0]  current_tag_next;
  logic [15:0] bytes_left;
  logic [15:0] bytes_left_next;
  logic [63:0] acc;
  logic [63:0] acc_next;
  logic [15:0] held_first;
  logic [15:0] held_first_next;
  logic [15:0] held_length;
  logic [15:0] held_length_next;
  logic        one_idx;
  logic        one_idx_next;

  logic        go;
  logic [63:0] shifted;
  logic [15:0] idx;
  logic        idx_ok;
  logic        field_done;

  assign go         = !item_empty && !res_full;
  assign item_pop   = go;
  assign shifted    = {acc[55:0], item.byte_value};
  assign idx        = shifted[15:0];
  assign idx_ok     = (idx != 16'd0) && (idx < pool_count);
  assign field_done = (bytes_left <= 16'd1);

  always_comb begin
    phase_next       = phase;
    current_tag_next = current_tag;
    bytes_left_next  = bytes_left;
    acc_next         = acc;
    held_first_next  = held_first;
    held_length_next = held_length;
    one_idx_next     = one_idx;
    res_push         = 1'b0;
    res              = '0;
    res.tag          = current_tag;
    if (go && phase != PH_HALT) begin
      if (item.end_of_stream) begin
        res_push   = 1'b1;
        res.kind   = ccp_pkg::KIND_ERROR;
        res.status = ccp_pkg::ST_EARLY_END;
        phase_next = PH_HALT;
        if (phase == PH_TAG) begin
          res.tag = ccp_pkg::TAG_NONE;
        end else if (phase == PH_UDATA) begin
          res.status      = ccp_pkg::ST_EARLY_UTF;
          res.text_length = held_length;
        end
      end else begin
        case (phase)
          PH_TAG: begin
            current_tag_next = item.byte_value;
            acc_next         = '0;
            one_idx_next     = 1'b0;
            case (item.layout)
              ccp_pkg::LAY_ONE_IDX: begin
                phase_next      = PH_IDX1;
                bytes_left_next = 16'd2;
                one_idx_next    = 1'b1;
              end
              ccp_pkg::LAY_TWO_IDX: begin
                phase_next      = PH_IDX1;
                bytes_left_next = 16'd2;
              end
              ccp_pkg::LAY_VAL4: begin
                phase_next      = PH_VALUE;
                bytes_left_next = 16'd4;
              end
              ccp_pkg::LAY_VAL8: begin
                phase_next      = PH_VALUE;
                bytes_left_next = 16'd8;
              end
              ccp_pkg::LAY_MH: begin
                phase_next      = PH_VALUE;
                bytes_left_next = 16'd3;
              end
              ccp_pkg::LAY_UTF8: begin
                phase_next      = PH_ULEN;
                bytes_left_next = 16'd2;
              end
              default: begin
                res_push   = 1'b1;
                res.kind   = ccp_pkg::KIND_ERROR;
                res.status = ccp_pkg::ST_BAD_TAG;
                res.tag    = item.byte_value;
                phase_next = PH_HALT;
              end
            endcase
          end
          PH_IDX1: begin
            acc_next        = shifted;
            bytes_left_next = bytes_left - 16'd1;
            if (field_done) begin
              if (!idx_ok) begin
                res_push        = 1'b1;
                res.kind        = ccp_pkg::KIND_ERROR;
                res.status      = ccp_pkg::ST_BAD_INDEX;
                res.first_index = idx;
                phase_next      = PH_HALT;
              end else if (one_idx) begin
                res_push        = 1'b1;
                res.kind        = ccp_pkg::KIND_ENTRY;
                res.status      = ccp_pkg::ST_OK;
                res.first_index = idx;
                phase_next      = PH_TAG;
              end else begin
                held_first_next = idx;
                acc_next        = '0;
                bytes_left_next = 16'd2;
                phase_next      = PH_IDX2;
              end
            end
          end
          PH_IDX2: begin
            acc_next        = shifted;
            bytes_left_next = bytes_left - 16'd1;
            if (field_done) begin
              res_push         = 1'b1;
              res.first_index  = held_first;
              res.second_index = idx;
              if (!idx_ok) begin
                res.kind   = ccp_pkg::KIND_ERROR;
                res.status = ccp_pkg::ST_BAD_INDEX;
                phase_next = PH_HALT;
              end else begin
                res.kind   = ccp_pkg::KIND_ENTRY;
                res.status = ccp_pkg::ST_OK;
                phase_next = PH_TAG;
              end
            end
          end
          PH_VALUE: begin
            acc_next        = shifted;
            bytes_left_next = bytes_left - 16'd1;
            if (field_done) begin
              res_push       = 1'b1;
              res.kind       = ccp_pkg::KIND_ENTRY;
              res.status     = ccp_pkg::ST_OK;
              res.value_bits = shifted;
              phase_next     = PH_TAG;
            end
          end
          PH_ULEN: begin
            acc_next        = shifted;
            bytes_left_next = bytes_left - 16'd1;
            if (field_done) begin
              held_length_next = idx;
              if (idx == 16'd0) begin
                res_push   = 1'b1;
                res.kind   = ccp_pkg::KIND_ENTRY;
                res.status = ccp_pkg::ST_OK;
                phase_next = PH_TAG;
              end else begin
                bytes_left_next = idx;
                phase_next      = PH_UDATA;
              end
            end
          end
          PH_UDATA: begin
            res_push        = 1'b1;
            res.text_length = held_length;
            res.data_byte   = item.byte_value;
            if (item.utf8_bad) begin
              res.kind   = ccp_pkg::KIND_ERROR;
              res.status = ccp_pkg::ST_BAD_UTF8;
              phase_next = PH_HALT;
            end else begin
              res.kind   = ccp_pkg::KIND_DATA;
              res.status = ccp_pkg::ST_OK;
              res.last   = field_done;
              if (bytes_left != 16'd0) begin
                bytes_left_next = bytes_left - 16'd1;
              end
              if (field_done) begin
                phase_next = PH_TAG;
              end
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TAG;
      current_tag <= '0;
      bytes_left  <= '0;
      acc         <= '0;
      held_first  <= '0;
      held_length <= '0;
      one_idx     <= 1'b0;
    end else begin
      phase       <= phase_next;
      current_tag <= current_tag_next;
      bytes_left  <= bytes_left_next;
      acc         <= acc_next;
      held_first  <= held_first_next;
      held_length <= held_length_next;
      one_idx     <= one_idx_next;
    end
  end

endmodule

// ----- hw/rtl/class_constant_pool_parser.sv -----
// class file constant pool parser, top level
// uses ccp_pkg, ccp_front, ccp_queue and ccp_back
// Bytes of the constant pool enter through a push/full queue port, one per
// cycle while full is low, with end_of_stream marking the end. The front end
// classifies each item and queues it; the back end parser takes one queued
// item per clock while the output queue is not full, so the block sustains
// one byte per cycle while results are popped. Each byte yields at most one
// result, registered in the output queue; the first error is reported and
// all later items are dropped until reset. The user must write pool_count
// through cfg_write/cfg_data while the block is idle; it is not enforced.
module class_constant_pool_parser #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ccp_pkg::in_item_t byte_item,
  input  logic              pop,
  output logic              empty,
  output ccp_pkg::result_t  result,
  input  logic              cfg_write,
  input  logic [15:0]       cfg_data
);

  logic [15:0]          pool_count;
  ccp_pkg::class_item_t classified;
  ccp_pkg::class_item_t mid_item;
  logic                 mid_empty;
  logic                 mid_pop;
  logic                 res_full;
  logic                 res_push;
  ccp_pkg::result_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_count <= '0;
    end else if (cfg_write) begin
      pool_count <= cfg_data;
    end
  end

  ccp_front u_front (
    .item       (byte_item),
    .classified (classified)
  );

  ccp_queue #(
    .WIDTH ($bits(ccp_pkg::class_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (classified),
    .pop   (mid_pop),
    .empty (mid_empty),
    .dout  (mid_item)
  );

  ccp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pool_count (pool_count),
    .item_empty (mid_empty),
    .item       (mid_item),
    .item_pop   (mid_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  ccp_queue #(
    .WIDTH ($bits(ccp_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res),
    .pop   (pop),
    .empty (empty),
    .dout  (result)
  );

endmodule

// ----- bench/ccp_stream_checker.sv -----
`timescale 1ns / 1ps
// byte-in / result-out checker for class_constant_pool_parser: predicts each result
// from the accepted bytes and the pool_count writes and compares it on pop
// depends on ccp_pkg
module ccp_stream_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  ccp_pkg::in_item_t byte_item,
  input  logic              pop,
  input  logic              empty,
  input  ccp_pkg::result_t  result,
  input  logic              cfg_write,
  input  logic [15:0]       cfg_data,
  output int                mismatches,
  output int                waiting,
  output int                results_seen
);
  import ccp_pkg::*;

  typedef enum logic [2:0] {
    P_TAG, P_IDX1, P_IDX2, P_VALUE, P_MH, P_ULEN, P_UDATA, P_HALT
  } parse_phase_t;

  parse_phase_t phase;
  logic [15:0]  pool_count;
  logic [7:0]   cur_tag;
  logic [15:0]  left;
  logic [63:0]  acc;
  logic [15:0]  held_first;
  logic [15:0]  held_len;
  logic         halted;
  result_t      due_results[$];
  result_t      want;

  function automatic bit idx_valid(input logic [15:0] v);
    return v != 16'd0 && v < pool_count;
  endfunction

  function automatic void open_field(input parse_phase_t nx, input logic [15:0] n);
    phase = nx;
    left  = n;
    acc   = '0;
  endfunction

  function automatic bit shift_in(input logic [7:0] b);
    acc = {acc[55:0], b};
    if (left > 16'd0) left = left - 16'd1;
    return left == 16'd0;
  endfunction

  task automatic parse_byte(input in_item_t it);
    result_t    r;
    logic [7:0] b;
    logic [1:0] kd;
    logic [2:0] st;
    bit         emit;
    bit         bad;
    r    = '0;
    b    = it.byte_value;
    kd   = KIND_ENTRY;
    st   = ST_OK;
    emit = 1'b0;
    bad  = 1'b0;
    if (halted) return;
    if (it.end_of_stream) begin
      emit = 1'b1;
      bad  = 1'b1;
      st   = ST_EARLY_END;
      if (phase == P_TAG) begin
        cur_tag = TAG_NONE;
      end else if (phase == P_UDATA) begin
        st = ST_EARLY_UTF;
        r.text_length = held_len;
      end
    end else begin
      case (phase)
        P_TAG: begin
          cur_tag = b;
          case (b)
            TAG_CLASS, TAG_STRING, TAG_METHODTYPE, TAG_FIELDREF, TAG_METHODREF,
            TAG_IFACEREF, TAG_NAMETYPE, TAG_INVOKEDYN: open_field(P_IDX1, 16'd2);
            TAG_INTEGER, TAG_FLOAT: open_field(P_VALUE, 16'd4);
            TAG_LONG, TAG_DOUBLE: open_field(P_VALUE, 16'd8);
            TAG_METHODHANDLE: open_field(P_MH, 16'd3);
            TAG_UTF8: open_field(P_ULEN, 16'd2);
            default: begin
              emit = 1'b1;
              bad  = 1'b1;
              st   = ST_BAD_TAG;
            end
          endcase
        end
        P_IDX1: if (shift_in(b)) begin
          if (!idx_valid(acc[15:0])) begin
            emit = 1'b1;
            bad  = 1'b1;
            st   = ST_BAD_INDEX;
            r.first_index = acc[15:0];
          end else if (cur_tag inside {TAG_CLASS, TAG_STRING, TAG_METHODTYPE}) begin
            emit = 1'b1;
            r.first_index = acc[15:0];
            phase = P_TAG;
          end else begin
            held_first = acc[15:0];
            open_field(P_IDX2, 16'd2);
          end
        end
        P_IDX2: if (shift_in(b)) begin
          emit = 1'b1;
          r.first_index  = held_first;
          r.second_index = acc[15:0];
          if (!idx_valid(acc[15:0])) begin
            bad = 1'b1;
            st  = ST_BAD_INDEX;
          end else begin
            phase = P_TAG;
          end
        end
        P_VALUE, P_MH: if (shift_in(b)) begin
          emit = 1'b1;
          r.value_bits = acc;
          phase = P_TAG;
        end
        P_ULEN: if (shift_in(b)) begin
          held_len = acc[15:0];
          if (held_len == 16'd0) begin
            emit = 1'b1;
            phase = P_TAG;
          end else begin
            phase = P_UDATA;
            left  = held_len;
          end
        end
        P_UDATA: begin
          emit = 1'b1;
          r.text_length = held_len;
          r.data_byte   = b;
          if (b == 8'd0 || b >= UTF8_BAD_FLOOR) begin
            bad = 1'b1;
            st  = ST_BAD_UTF8;
          end else begin
            kd = KIND_DATA;
            r.last = (left <= 16'd1);
            if (left > 16'd0) left = left - 16'd1;
            if (left == 16'd0) phase = P_TAG;
          end
        end
        default: ;
      endcase
    end
    if (bad) begin
      halted = 1'b1;
      phase  = P_HALT;
      kd     = KIND_ERROR;
    end
    if (emit) begin
      r.kind   = kd;
      r.tag    = cur_tag;
      r.status = st;
      due_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase        = P_TAG;
      pool_count   = '0;
      cur_tag      = '0;
      left         = '0;
      acc          = '0;
      held_first   = '0;
      held_len     = '0;
      halted       = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      due_results.delete();
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d tag %0h status %0d",
                 result.kind, result.tag, result.status);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          results_seen++;
          check_field("kind", 64'(want.kind), 64'(result.kind));
          check_field("tag", 64'(want.tag), 64'(result.tag));
          check_field("status", 64'(want.status), 64'(result.status));
          check_field("first_index", 64'(want.first_index), 64'(result.first_index));
          check_field("second_index", 64'(want.second_index), 64'(result.second_index));
          check_field("value_bits", want.value_bits, result.value_bits);
          check_field("text_length", 64'(want.text_length), 64'(result.text_length));
          check_field("data_byte", 64'(want.data_byte), 64'(result.data_byte));
          check_field("last", 64'(want.last), 64'(result.last));
        end
      end
      if (push && !full) parse_byte(byte_item);
      if (cfg_write) pool_count = cfg_data;
    end
    waiting = due_results.size();
  end

endmodule

// ----- bench/tb_class_constant_pool_parser.sv -----
`timescale 1ns / 1ps
// top of the class_constant_pool_parser bench: clock, reset, byte stream, pops,
// pool_count writes and the verdict; checking is done in ccp_stream_checker
// depends on ccp_pkg, ccp_stream_checker and the parser rtl
module tb_class_constant_pool_parser;
  import ccp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 130;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  in_item_t    byte_item;
  logic        pop;
  logic        empty;
  result_t     result;
  logic        cfg_write;
  logic [15:0] cfg_data;

  int mismatches;
  int waiting;
  int results_seen;
  int bytes_sent;
  int cycles = 0;
  bit steady;
  bit gap_on;

  class_constant_pool_parser dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .byte_item (byte_item),
    .pop       (pop),
    .empty     (empty),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  ccp_stream_checker chk (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .byte_item    (byte_item),
    .pop          (pop),
    .empty        (empty),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .waiting      (waiting),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout: run stopped after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random pop stalls until the final stretch
  initial begin
    pop = 1'b0;
    forever begin
      if (!steady && $urandom_range(0, 6) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (!steady && gap_on && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    push      <= 1'b1;
    byte_item <= '{byte_value: b, end_of_stream: eos};
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_u16(input logic [15:0] v);
    send_byte(v[15:8], 1'b0);
    send_byte(v[7:0], 1'b0);
  endtask

  function automatic logic [7:0] pick_tag(input bit with_index);
    case ($urandom_range(0, with_index ? 14 : 6))
      0, 1:    return TAG_UTF8;
      2:       return TAG_INTEGER;
      3:       return TAG_FLOAT;
      4:       return TAG_LONG;
      5:       return TAG_DOUBLE;
      6:       return TAG_METHODHANDLE;
      7:       return TAG_CLASS;
      8:       return TAG_STRING;
      9:       return TAG_METHODTYPE;
      10:      return TAG_FIELDREF;
      11:      return TAG_METHODREF;
      12:      return TAG_IFACEREF;
      13:      return TAG_NAMETYPE;
      default: return TAG_INVOKEDYN;
    endcase
  endfunction

  function automatic logic [15:0] pick_index(input logic [15:0] pc);
    case ($urandom_range(0, 7))
      0:       return 16'd1;
      1:       return pc - 16'd1;
      default: return 16'($urandom_range(1, pc - 16'd1));
    endcase
  endfunction

  // one well-formed entry; index kinds only when some index is valid
  task automatic send_entry(input logic [15:0] pc);
    logic [7:0]  tag;
    logic [15:0] len;
    int          n;
    if ($urandom_range(0, 7) == 0) gap_on = !gap_on;
    tag = pick_tag(pc >= 16'd2);
    send_byte(tag, 1'b0);
    if (tag inside {TAG_CLASS, TAG_STRING, TAG_METHODTYPE}) begin
      send_u16(pick_index(pc));
    end else if (tag inside {TAG_FIELDREF, TAG_METHODREF, TAG_IFACEREF, TAG_NAMETYPE,
                             TAG_INVOKEDYN}) begin
      send_u16(pick_index(pc));
      send_u16(pick_index(pc));
    end else if (tag == TAG_UTF8) begin
      len = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(7, 300))
                                         : 16'($urandom_range(0, 6));
      send_u16(len);
      repeat (len) send_byte(8'($urandom_range(1, int'(UTF8_BAD_FLOOR) - 1)), 1'b0);
    end else begin
      n = (tag == TAG_LONG || tag == TAG_DOUBLE) ? 8 : (tag == TAG_METHODHANDLE) ? 3 : 4;
      repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    logic [15:0] pc;
    logic [15:0] bad_idx;
    logic [7:0]  bad_tag;
    int          start;
    int          fault;
    rst        = 1'b1;
    push       = 1'b0;
    byte_item  = '0;
    cfg_write  = 1'b0;
    cfg_data   = '0;
    steady     = 1'b0;
    gap_on     = 1'b1;
    bytes_sent = 0;
    pc         = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       pc = 16'hFFFF;
        2:       pc = 16'd2;
        3:       pc = 16'd0;
        4:       pc = 16'd1;
        default: pc = 16'($urandom_range(2, 65535));
      endcase
      drain();
      cfg_write <= 1'b1;
      cfg_data  <= pc;
      @(posedge clk);
      cfg_write <= 1'b0;
      if (ph == 0) begin
        send_byte(TAG_CLASS, 1'b0);
        send_u16(16'd1);
        send_byte(TAG_STRING, 1'b0);
        send_u16(16'hFFFE);
        send_byte(TAG_METHODREF, 1'b0);
        send_u16(16'd1);
        send_u16(16'hFFFE);
        send_byte(TAG_INTEGER, 1'b0);
        repeat (4) send_byte(8'h00, 1'b0);
        send_byte(TAG_LONG, 1'b0);
        repeat (8) send_byte(8'hFF, 1'b0);
        send_byte(TAG_METHODHANDLE, 1'b0);
        send_u16(16'h8001);
        send_byte(8'h7F, 1'b0);
        send_byte(TAG_UTF8, 1'b0);
        send_u16(16'd0);
        send_byte(TAG_UTF8, 1'b0);
        send_u16(16'd2);
        send_byte(8'h01, 1'b0);
        send_byte(8'hEF, 1'b0);
      end
      if (ph == 5) steady = 1'b1;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) send_entry(pc);
    end

    // errors are sticky until reset, so the stream ends with one broken case
    fault   = $urandom_range(0, 6);
    bad_idx = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(pc, 65535));
    case (fault)
      0: begin
        do begin
          bad_tag = 8'($urandom_range(0, 255));
        end while (bad_tag inside {TAG_UTF8, TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE,
                                   TAG_CLASS, TAG_STRING, TAG_FIELDREF, TAG_METHODREF,
                                   TAG_IFACEREF, TAG_NAMETYPE, TAG_METHODHANDLE,
                                   TAG_METHODTYPE, TAG_INVOKEDYN});
        send_byte(bad_tag, 1'b0);
      end
      1: send_byte(8'($urandom_range(0, 255)), 1'b1);
      2: begin
        if ($urandom_range(0, 1) == 0) begin
          send_byte(TAG_LONG, 1'b0);
          repeat ($urandom_range(0, 7)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_byte(TAG_UTF8, 1'b0);
          repeat ($urandom_range(0, 1)) send_byte(8'h00, 1'b0);
        end
        send_byte(8'h00, 1'b1);
      end
      3: begin
        send_byte(TAG_UTF8, 1'b0);
        send_u16(16'd5);
        repeat ($urandom_range(0, 4)) send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b1);
      end
      4: begin
        send_byte(($urandom_range(0, 1) == 0) ? TAG_CLASS : TAG_FIELDREF, 1'b0);
        send_u16(bad_idx);
      end
      5: begin
        send_byte(TAG_NAMETYPE, 1'b0);
        send_u16(pick_index(pc));
        send_u16(bad_idx);
      end
      default: begin
        send_byte(TAG_UTF8, 1'b0);
        send_u16(16'd4);
        repeat ($urandom_range(0, 3)) send_byte(8'h61, 1'b0);
        send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(240, 255)), 1'b0);
      end
    endcase
    repeat (12) send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));

    drain();
    $display("%0d bytes pushed over six pool_count settings, %0d results checked",
             bytes_sent, results_seen);
    $display("stream closed by fault case %0d, later items dropped", fault);
    if (mismatches == 0 && waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
